@@ src/gtr_pkg.sv @@
// ----------------------------------------------------------------------------
// gtr_pkg: shared types and constants for the glyph text renderer
// Holds the command and result records, the operation codes, screen limits
// and the display controller command bytes.
// ----------------------------------------------------------------------------
`default_nettype none

package gtr_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 160;
  localparam int GLYPH_WORDS   = 4096;
  localparam int GLYPH_AW      = $clog2(GLYPH_WORDS);

  localparam logic [7:0] CMD_COLUMN = 8'h2A;
  localparam logic [7:0] CMD_ROW    = 8'h2B;
  localparam logic [7:0] CMD_WRITE  = 8'h2C;

  localparam logic [7:0] CODE_FIRST = 8'd32;
  localparam logic [7:0] CODE_LAST  = 8'd126;
  localparam logic [7:0] CODE_SPACE = 8'd32;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BEGIN = 2'd1,
    OP_PUT   = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_FG_COLOR     = 2'd0,
    CFG_BG_COLOR     = 2'd1,
    CFG_GLYPH_WIDTH  = 2'd2,
    CFG_GLYPH_HEIGHT = 2'd3
  } cfg_index_t;

  typedef struct packed {
    op_t                 op;
    logic [7:0]          start_x;
    logic [7:0]          start_y;
    logic [7:0]          char_code;
    logic                code_ok;
    logic [GLYPH_AW-1:0] glyph_addr;
    logic [15:0]         glyph_word;
  } cmd_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] out_byte;
    logic       is_data;
    logic       last;
  } result_t;

  typedef struct packed {
    logic       we;
    cfg_index_t index;
    logic [15:0] data;
  } cfg_write_t;

endpackage

`default_nettype wire

@@ src/gtr_front.sv @@
// ----------------------------------------------------------------------------
// gtr_front: input decode and command queue
// Unpacks input beats into commands, checks the character range and holds
// them in a short queue until the back end takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module gtr_front import gtr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,
  input  wire logic [1:0]  s_tuser,
  output logic             head_valid,
  output cmd_t             head,
  input  wire logic        pop
);

  cmd_t                queue [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  cmd_t                in_cmd;
  logic                push;
  logic                take;

  always_comb begin
    in_cmd.op         = op_t'(s_tuser);
    in_cmd.start_x    = s_tdata[7:0];
    in_cmd.start_y    = s_tdata[15:8];
    in_cmd.char_code  = s_tdata[23:16];
    in_cmd.code_ok    = (s_tdata[23:16] >= CODE_FIRST) && (s_tdata[23:16] <= CODE_LAST);
    in_cmd.glyph_addr = s_tdata[24 +: GLYPH_AW];
    in_cmd.glyph_word = s_tdata[51:36];
  end

  assign s_tready   = (count != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign push       = s_tvalid && s_tready;
  assign head_valid = (count != '0);
  assign head       = queue[rd_ptr];
  assign take       = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/gtr_back.sv @@
// ----------------------------------------------------------------------------
// gtr_back: command execution, glyph memory and output register
// Runs one command per cycle while the output is not stalled: glyph loads,
// cursor moves, character setup and header and pixel bytes, with one registered output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module gtr_back import gtr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  cfg_write_t      cfg,
  input  wire logic       head_valid,
  input  cmd_t            head,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output result_t         out_res
);

  localparam logic [3:0] HDR_COL_CMD   = 4'd0;
  localparam logic [3:0] HDR_X0        = 4'd2;
  localparam logic [3:0] HDR_X1        = 4'd4;
  localparam logic [3:0] HDR_ROW_CMD   = 4'd5;
  localparam logic [3:0] HDR_Y0        = 4'd7;
  localparam logic [3:0] HDR_Y1        = 4'd9;
  localparam logic [3:0] HDR_WRITE_CMD = 4'd10;
  localparam logic [3:0] PIXEL_PHASE   = 4'd11;
  localparam int         PROD_W        = 13;

  // configuration
  logic [15:0] fg_color;
  logic [15:0] bg_color;
  logic [4:0]  glyph_width;
  logic [5:0]  glyph_height;
  logic [4:0]  w_eff;
  logic [5:0]  h_eff;

  // render state
  logic [7:0]          cursor_x, cursor_x_next;
  logic [7:0]          cursor_y, cursor_y_next;
  logic                stopped, stopped_next;
  logic                busy, busy_next;
  logic [3:0]          header_index, header_index_next;
  logic [4:0]          row_count, row_count_next;
  logic [3:0]          col_count, col_count_next;
  logic                low_half, low_half_next;
  logic [GLYPH_AW-1:0] glyph_base, glyph_base_next;
  logic [7:0]          origin_x, origin_x_next;
  logic [7:0]          origin_y, origin_y_next;

  logic [15:0]         glyph_mem [GLYPH_WORDS];
  logic [15:0]         row_bits;
  logic                rd_en;
  logic [GLYPH_AW-1:0] rd_addr;
  logic                wr_en;

  result_t             res;
  logic                res_valid;
  logic [PROD_W-1:0]   base_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color     <= 16'hFFFF;
      bg_color     <= 16'h0000;
      glyph_width  <= 5'd7;
      glyph_height <= 6'd10;
    end else if (cfg.we) begin
      case (cfg.index)
        CFG_FG_COLOR:     fg_color     <= cfg.data;
        CFG_BG_COLOR:     bg_color     <= cfg.data;
        CFG_GLYPH_WIDTH:  glyph_width  <= cfg.data[4:0];
        CFG_GLYPH_HEIGHT: glyph_height <= cfg.data[5:0];
        default: ;
      endcase
    end
  end

  // clamp out-of-range sizes
  always_comb begin
    if (glyph_width == '0) begin
      w_eff = 5'd1;
    end else if (glyph_width > 5'd16) begin
      w_eff = 5'd16;
    end else begin
      w_eff = glyph_width;
    end
    if (glyph_height == '0) begin
      h_eff = 6'd1;
    end else if (glyph_height > 6'd32) begin
      h_eff = 6'd32;
    end else begin
      h_eff = glyph_height;
    end
  end

  assign pop = head_valid && (!out_valid || out_ready);

  // first word of the glyph, code offset times height
  assign base_prod = PROD_W'((head.char_code - CODE_FIRST) & 8'h7F) * PROD_W'(h_eff);

  always_comb begin
    logic [8:0]  sum_x;
    logic [8:0]  ny;
    logic [9:0]  ny_end;
    logic [15:0] color;
    logic [4:0]  col_inc;
    logic [5:0]  row_inc;

    cursor_x_next     = cursor_x;
    cursor_y_next     = cursor_y;
    stopped_next      = stopped;
    busy_next         = busy;
    header_index_next = header_index;
    row_count_next    = row_count;
    col_count_next    = col_count;
    low_half_next     = low_half;
    glyph_base_next   = glyph_base;
    origin_x_next     = origin_x;
    origin_y_next     = origin_y;
    rd_en             = 1'b0;
    rd_addr           = glyph_base;
    wr_en             = 1'b0;
    res               = '0;
    res_valid         = 1'b0;

    sum_x   = {1'b0, cursor_x} + {4'b0, w_eff};
    ny      = {1'b0, cursor_y} + {3'b0, h_eff};
    ny_end  = {1'b0, ny} + {4'b0, h_eff};
    color   = row_bits[~col_count] ? fg_color : bg_color;
    col_inc = {1'b0, col_count} + 5'd1;
    row_inc = {1'b0, row_count} + 6'd1;

    if (pop) begin
      case (head.op)
        OP_LOAD: begin
          wr_en = 1'b1;
        end
        OP_BEGIN: begin
          cursor_x_next = head.start_x;
          cursor_y_next = head.start_y;
          stopped_next  = 1'b0;
        end
        OP_PUT: begin
          if (busy || stopped || !head.code_ok) begin
            res.kind  = 1'b1;
            res_valid = 1'b1;
          end else if (sum_x >= 9'(SCREEN_WIDTH)) begin
            // wrap to the next line
            cursor_x_next = '0;
            cursor_y_next = ny[7:0];
            if (ny_end >= 10'(SCREEN_HEIGHT)) begin
              stopped_next = 1'b1;
              res.kind     = 1'b1;
              res_valid    = 1'b1;
            end else if (head.char_code != CODE_SPACE) begin
              origin_x_next     = '0;
              origin_y_next     = ny[7:0];
              glyph_base_next   = base_prod[GLYPH_AW-1:0];
              busy_next         = 1'b1;
              header_index_next = '0;
              row_count_next    = '0;
              col_count_next    = '0;
              low_half_next     = 1'b0;
              cursor_x_next     = {3'b0, w_eff};
            end
          end else begin
            origin_x_next     = cursor_x;
            origin_y_next     = cursor_y;
            glyph_base_next   = base_prod[GLYPH_AW-1:0];
            busy_next         = 1'b1;
            header_index_next = '0;
            row_count_next    = '0;
            col_count_next    = '0;
            low_half_next     = 1'b0;
            cursor_x_next     = sum_x[7:0];
          end
        end
        OP_TICK: begin
          if (busy) begin
            res_valid = 1'b1;
            if (header_index < PIXEL_PHASE) begin
              res.is_data = 1'b1;
              case (header_index)
                HDR_COL_CMD: begin
                  res.out_byte = CMD_COLUMN;
                  res.is_data  = 1'b0;
                end
                HDR_X0:        res.out_byte = origin_x;
                HDR_X1:        res.out_byte = origin_x + {3'b0, w_eff} - 8'd1;
                HDR_ROW_CMD: begin
                  res.out_byte = CMD_ROW;
                  res.is_data  = 1'b0;
                end
                HDR_Y0:        res.out_byte = origin_y;
                HDR_Y1:        res.out_byte = origin_y + {2'b0, h_eff} - 8'd1;
                HDR_WRITE_CMD: begin
                  res.out_byte = CMD_WRITE;
                  res.is_data  = 1'b0;
                end
                default:       res.out_byte = '0;
              endcase
              header_index_next = header_index + 4'd1;
              if (header_index == HDR_WRITE_CMD) begin
                // fetch the first glyph row for the pixel phase
                row_count_next = '0;
                col_count_next = '0;
                low_half_next  = 1'b0;
                rd_en          = 1'b1;
                rd_addr        = glyph_base;
              end
            end else begin
              res.is_data = 1'b1;
              if (!low_half) begin
                res.out_byte  = color[15:8];
                low_half_next = 1'b1;
              end else begin
                res.out_byte  = color[7:0];
                low_half_next = 1'b0;
                if (col_inc >= w_eff) begin
                  col_count_next = '0;
                  if (row_inc >= h_eff) begin
                    busy_next         = 1'b0;
                    header_index_next = '0;
                    row_count_next    = '0;
                    res.last          = 1'b1;
                  end else begin
                    row_count_next = row_inc[4:0];
                    rd_en          = 1'b1;
                    rd_addr        = glyph_base + GLYPH_AW'(row_inc);
                  end
                end else begin
                  col_count_next = col_inc[3:0];
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      glyph_mem[head.glyph_addr] <= head.glyph_word;
    end
    if (rd_en) begin
      row_bits <= glyph_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x     <= '0;
      cursor_y     <= '0;
      stopped      <= 1'b0;
      busy         <= 1'b0;
      header_index <= '0;
      row_count    <= '0;
      col_count    <= '0;
      low_half     <= 1'b0;
      glyph_base   <= '0;
      origin_x     <= '0;
      origin_y     <= '0;
      out_valid    <= 1'b0;
    end else begin
      cursor_x     <= cursor_x_next;
      cursor_y     <= cursor_y_next;
      stopped      <= stopped_next;
      busy         <= busy_next;
      header_index <= header_index_next;
      row_count    <= row_count_next;
      col_count    <= col_count_next;
      low_half     <= low_half_next;
      glyph_base   <= glyph_base_next;
      origin_x     <= origin_x_next;
      origin_y     <= origin_y_next;
      if (pop && res_valid) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      out_res <= res;
    end
  end

endmodule

`default_nettype wire

@@ src/glyph_text_renderer_top.sv @@
// ----------------------------------------------------------------------------
// glyph_text_renderer_top: bitmap font text renderer
// Turns glyph loads, string starts, characters and ticks into a display
// controller byte stream: column, row and write commands, then pixels.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake             payload
//   s_*       in    s_tvalid / s_tready   s_tuser op, s_tdata coords, code, glyph
//   m_*       out   m_tvalid / m_tready   m_tdata byte, m_tuser kind/dc, m_tlast
//   cfg_*     in    cfg_we                cfg_index, cfg_data
//
// one beat per cycle in and out when neither side stalls; an input beat
// reaches the output through the queue and the output register
// rst is synchronous; glyph memory is not cleared and holds garbage until loaded
// a four-entry queue lets input keep flowing while the output side stalls
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_text_renderer_top import gtr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  // input beats
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [7:0] start_x, [15:8] start_y, [23:16] char_code, [35:24] glyph_addr,
  // [51:36] glyph_word, [55:52] zero
  input  wire logic [55:0] s_tdata,
  // [1:0] operation
  input  wire logic [1:0]  s_tuser,
  // output beats
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [7:0] out_byte
  output logic [7:0]       m_tdata,
  // [0] kind, [1] is_data
  output logic [1:0]       m_tuser,
  output logic             m_tlast,
  // configuration writes
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cmd_t       head;
  logic       head_valid;
  logic       pop;
  result_t    out_res;
  cfg_write_t cfg;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index_t'(cfg_index);
  assign cfg.data  = cfg_data;

  // decode and queue
  gtr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // execution, glyph memory and output register
  gtr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_res    (out_res)
  );

  assign m_tdata = out_res.out_byte;
  assign m_tuser = {out_res.is_data, out_res.kind};
  assign m_tlast = out_res.last;

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the glyph text renderer
// A directed table walks reset behavior, code limits, wrap, skipped space,
// stop and begin-while-busy; then randomized phases over several glyph sizes
// and colors run strings of characters drained by tick beats. Every output
// beat is compared field by field against a built-in behavioral predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import gtr_pkg::*;

  // header positions of the per-character byte sequence
  localparam logic [3:0] HDR_COL_CMD = 4'd0;
  localparam logic [3:0] HDR_X0      = 4'd2;
  localparam logic [3:0] HDR_X1      = 4'd4;
  localparam logic [3:0] HDR_ROW_CMD = 4'd5;
  localparam logic [3:0] HDR_Y0      = 4'd7;
  localparam logic [3:0] HDR_Y1      = 4'd9;
  localparam logic [3:0] HDR_WR_CMD  = 4'd10;
  localparam logic [3:0] HDR_DONE    = 4'd11;

  // run shape
  localparam int NUM_PHASES     = 8;
  localparam int RAND_PER_PHASE = 120;
  localparam int DRAIN_CYCLES   = 20;
  // slowest run is a few thousand beats, each with at most one idle gap and
  // a stalled receiver; this is many times that
  localparam int TIMEOUT_CYCLES = 300000;

  localparam result_t DROPPED = '{kind: 1'b1, out_byte: 8'h00, is_data: 1'b0, last: 1'b0};

  // how a directed row is checked
  typedef enum logic [1:0] {
    CHK_MODEL,   // expectation from the predictor
    CHK_NONE,    // typed: no beat at all
    CHK_DROP     // typed: one dropped-character beat
  } chk_t;

  typedef struct {
    op_t        op;
    logic [7:0] sx;
    logic [7:0] sy;
    logic [7:0] code;
    logic [11:0] addr;
    logic [15:0] word;
  } text_op_t;

  typedef struct {
    op_t  op;
    int   a;
    int   b;
    int   reps;
    chk_t chk;
  } dir_row_t;

  // ---------------------------------------------------------------------------
  // clock, reset and dut stimulus, all known from time zero
  // ---------------------------------------------------------------------------
  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata   = '0;
  logic [1:0]  s_tuser   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [7:0]  m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  glyph_text_renderer_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // predictor state, mirrors the renderer after reset
  // ---------------------------------------------------------------------------
  logic [15:0] font_rom [GLYPH_WORDS];
  bit          font_written [GLYPH_WORDS];
  logic [15:0] fg_reg      = 16'hFFFF;
  logic [15:0] bg_reg      = 16'h0000;
  logic [4:0]  width_reg   = 5'd7;
  logic [5:0]  height_reg  = 6'd10;
  logic [7:0]  pen_x       = '0;
  logic [7:0]  pen_y       = '0;
  logic        halted      = 1'b0;
  logic        drawing     = 1'b0;
  logic [3:0]  hdr_pos     = '0;
  logic [4:0]  row_idx     = '0;
  logic [3:0]  col_idx     = '0;
  logic        second_byte = 1'b0;
  logic [15:0] cur_row     = '0;
  logic [11:0] font_base   = '0;
  logic [7:0]  char_x      = '0;
  logic [7:0]  char_y      = '0;

  result_t  expected_beats [$];
  dir_row_t dir_rows [$];
  int       ready_codes [$];

  int  cycles        = 0;
  int  errors        = 0;
  int  beats_in      = 0;
  int  beats_out     = 0;
  int  glyphs_drawn  = 0;
  int  chars_dropped = 0;
  int  settings_run  = 0;
  // no idling on either side while set
  bit  calm          = 1'b0;

  // glyph sizes per phase; out-of-range raw values act as the nearest limit
  int ph_w [NUM_PHASES] = '{7, 0, 3, 31, 2, 16, 5, 1};
  int ph_h [NUM_PHASES] = '{10, 0, 4, 3, 63, 1, 6, 32};

  function automatic int glyph_w();
    if (width_reg == 0) return 1;
    return (width_reg > 16) ? 16 : int'(width_reg);
  endfunction

  function automatic int glyph_h();
    if (height_reg == 0) return 1;
    return (height_reg > 32) ? 32 : int'(height_reg);
  endfunction

  // one accepted command in, at most one stream beat out
  function automatic bit render_step(text_op_t it, output result_t res);
    int          w;
    int          h;
    int          ny;
    bit          wrapped;
    logic [15:0] color;
    logic [7:0]  b;
    logic        d;
    w = glyph_w();
    h = glyph_h();
    res = DROPPED;
    render_step = 1'b0;
    case (it.op)
      OP_LOAD: begin
        font_rom[it.addr % GLYPH_WORDS] = it.word;
        font_written[it.addr % GLYPH_WORDS] = 1'b1;
      end
      OP_BEGIN: begin
        pen_x = it.sx;
        pen_y = it.sy;
        halted = 1'b0;
      end
      OP_PUT: begin
        if (drawing || halted || it.code < CODE_FIRST || it.code > CODE_LAST) begin
          render_step = 1'b1;
        end else begin
          wrapped = 1'b0;
          if (int'(pen_x) + w >= SCREEN_WIDTH) begin
            // next line; the bottom check uses the unwrapped row
            wrapped = 1'b1;
            pen_x = '0;
            ny = int'(pen_y) + h;
            pen_y = ny[7:0];
            if (ny + h >= SCREEN_HEIGHT) begin
              halted = 1'b1;
              render_step = 1'b1;
            end
          end
          if (!render_step && !(wrapped && it.code == CODE_SPACE)) begin
            char_x = pen_x;
            char_y = pen_y;
            font_base = 12'(((int'(it.code) - int'(CODE_FIRST)) * h) % GLYPH_WORDS);
            drawing = 1'b1;
            hdr_pos = HDR_COL_CMD;
            row_idx = '0;
            col_idx = '0;
            second_byte = 1'b0;
            pen_x = pen_x + 8'(w);
            glyphs_drawn++;
          end
        end
        if (render_step) chars_dropped++;
      end
      OP_TICK: begin
        if (drawing) begin
          render_step = 1'b1;
          if (hdr_pos < HDR_DONE) begin
            d = 1'b1;
            b = 8'h00;
            case (hdr_pos)
              HDR_COL_CMD: begin b = CMD_COLUMN; d = 1'b0; end
              HDR_X0:      b = char_x;
              HDR_X1:      b = char_x + 8'(w - 1);
              HDR_ROW_CMD: begin b = CMD_ROW; d = 1'b0; end
              HDR_Y0:      b = char_y;
              HDR_Y1:      b = char_y + 8'(h - 1);
              HDR_WR_CMD:  begin b = CMD_WRITE; d = 1'b0; end
              default:     b = 8'h00;
            endcase
            hdr_pos = hdr_pos + 4'd1;
            if (hdr_pos == HDR_DONE) begin
              row_idx = '0;
              col_idx = '0;
              second_byte = 1'b0;
              cur_row = font_rom[font_base];
            end
            res = '{kind: 1'b0, out_byte: b, is_data: d, last: 1'b0};
          end else begin
            color = cur_row[4'd15 - col_idx] ? fg_reg : bg_reg;
            if (!second_byte) begin
              second_byte = 1'b1;
              res = '{kind: 1'b0, out_byte: color[15:8], is_data: 1'b1, last: 1'b0};
            end else begin
              second_byte = 1'b0;
              res = '{kind: 1'b0, out_byte: color[7:0], is_data: 1'b1, last: 1'b0};
              if (int'(col_idx) + 1 >= w) begin
                col_idx = '0;
                if (int'(row_idx) + 1 >= h) begin
                  drawing = 1'b0;
                  hdr_pos = HDR_COL_CMD;
                  row_idx = '0;
                  res.last = 1'b1;
                end else begin
                  row_idx = row_idx + 5'd1;
                  cur_row = font_rom[font_base + 12'(row_idx)];
                end
              end else begin
                col_idx = col_idx + 4'd1;
              end
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic note_mismatch(string msg);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  // one input beat: optional gap, hold until accepted, then predict
  task automatic drive_item(text_op_t it, chk_t chk);
    result_t res;
    bit      got;
    if (!calm && $urandom_range(0, 99) < 23) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.op;
    s_tdata  <= {4'b0000, it.word, it.addr, it.code, it.sy, it.sx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    beats_in++;
    got = render_step(it, res);
    case (chk)
      CHK_MODEL: if (got) expected_beats.push_back(res);
      CHK_DROP:  expected_beats.push_back(DROPPED);
      default:   ;
    endcase
  endtask

  // register write, only issued while the renderer is idle
  task automatic set_reg(cfg_index_t idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FG_COLOR:     fg_reg = val;
      CFG_BG_COLOR:     bg_reg = val;
      CFG_GLYPH_WIDTH:  width_reg = val[4:0];
      CFG_GLYPH_HEIGHT: height_reg = val[5:0];
      default:          ;
    endcase
    @(posedge clk);
  endtask

  // stop sending, let every expected beat come out, then let the pipe empty
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_row(op_t op, int a, int b, int reps, chk_t chk);
    dir_rows.push_back('{op: op, a: a, b: b, reps: reps, chk: chk});
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random backpressure, with a calm phase of none
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 19);
  end

  // ---------------------------------------------------------------------------
  // output checker: each beat against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      beats_out++;
      if (expected_beats.size() == 0) begin
        note_mismatch($sformatf("unexpected beat byte %02h user %02b last %0b",
                                m_tdata, m_tuser, m_tlast));
      end else begin
        want = expected_beats.pop_front();
        if (m_tuser[0] !== want.kind)
          note_mismatch($sformatf("kind %0b, want %0b", m_tuser[0], want.kind));
        if (m_tdata !== want.out_byte)
          note_mismatch($sformatf("byte %02h, want %02h", m_tdata, want.out_byte));
        if (m_tuser[1] !== want.is_data)
          note_mismatch($sformatf("is_data %0b, want %0b", m_tuser[1], want.is_data));
        if (m_tlast !== want.last)
          note_mismatch($sformatf("last %0b, want %0b", m_tlast, want.last));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= TIMEOUT_CYCLES) begin
      $display("timeout with %0d beats still expected", expected_beats.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    text_op_t    it;
    dir_row_t    row;
    logic [15:0] wdat;
    int          p;
    int          k;
    int          c;
    int          r;
    int          h;
    int          n;
    int          sel;
    bit          ok;
    int          glyph_set [5];

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // smallest glyph so a full character is only a handful of ticks
    set_reg(CFG_GLYPH_WIDTH, 16'd1);
    set_reg(CFG_GLYPH_HEIGHT, 16'd1);

    // directed table: reset behavior, code limits, wrap, stop, busy cases
    add_row(OP_TICK, 0, 0, 1, CHK_NONE);                     // idle tick
    add_row(OP_PUT, 31, 0, 1, CHK_DROP);                     // just below printable
    add_row(OP_PUT, 127, 0, 1, CHK_DROP);                    // just above printable
    add_row(OP_PUT, 0, 0, 1, CHK_DROP);
    add_row(OP_PUT, 255, 0, 1, CHK_DROP);
    add_row(OP_LOAD, 0, 16'h8000, 1, CHK_NONE);              // space glyph, left pixel set
    add_row(OP_LOAD, 94, 16'h0000, 1, CHK_NONE);             // tilde glyph at height 1
    add_row(OP_LOAD, GLYPH_WORDS - 1, 16'hFFFF, 1, CHK_NONE); // top address, all ones
    add_row(OP_BEGIN, 0, 0, 1, CHK_NONE);
    add_row(OP_PUT, 126, 0, 1, CHK_NONE);                    // accepted, bytes come on ticks
    add_row(OP_PUT, 32, 0, 1, CHK_DROP);                     // busy
    add_row(OP_TICK, 0, 0, int'(HDR_DONE) + 2, CHK_MODEL);
    add_row(OP_BEGIN, SCREEN_WIDTH - 1, 0, 1, CHK_NONE);
    add_row(OP_PUT, 32, 0, 1, CHK_NONE);                     // wraps: space skipped
    add_row(OP_PUT, 32, 0, 1, CHK_NONE);                     // drawn at start of line
    add_row(OP_TICK, 0, 0, int'(HDR_DONE) + 2, CHK_MODEL);
    add_row(OP_BEGIN, 255, 255, 1, CHK_NONE);
    add_row(OP_PUT, 33, 0, 1, CHK_DROP);                     // wrap crosses bottom
    add_row(OP_PUT, 32, 0, 1, CHK_DROP);                     // after stop
    add_row(OP_BEGIN, 10, 10, 1, CHK_NONE);
    add_row(OP_PUT, 32, 0, 1, CHK_NONE);
    add_row(OP_BEGIN, 20, 20, 1, CHK_NONE);                  // begin while busy
    add_row(OP_TICK, 0, 0, int'(HDR_DONE) + 2, CHK_MODEL);
    add_row(OP_PUT, 32, 0, 1, CHK_NONE);                     // lands at the new cursor
    add_row(OP_TICK, 0, 0, int'(HDR_DONE) + 2, CHK_MODEL);
    add_row(OP_TICK, 0, 0, 1, CHK_NONE);                     // idle again

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      repeat (row.reps) begin
        // unused fields carry noise
        it.op   = row.op;
        it.sx   = 8'($urandom);
        it.sy   = 8'($urandom);
        it.code = 8'($urandom);
        it.addr = 12'($urandom);
        it.word = 16'($urandom);
        case (row.op)
          OP_LOAD:  begin it.addr = 12'(row.a); it.word = 16'(row.b); end
          OP_BEGIN: begin it.sx = 8'(row.a); it.sy = 8'(row.b); end
          OP_PUT:   it.code = 8'(row.a);
          default:  ;
        endcase
        drive_item(it, row.chk);
      end
    end

    // randomized phases, one register setting each
    for (p = 0; p < NUM_PHASES; p++) begin
      settle();
      calm = (p == 2);
      case (p)
        1:       begin set_reg(CFG_FG_COLOR, 16'h0000); set_reg(CFG_BG_COLOR, 16'hFFFF); end
        5:       begin set_reg(CFG_FG_COLOR, 16'hFFFF); set_reg(CFG_BG_COLOR, 16'h0000); end
        default: begin
          set_reg(CFG_FG_COLOR, 16'($urandom));
          set_reg(CFG_BG_COLOR, 16'($urandom));
        end
      endcase
      // junk in the unused upper bits of the size registers
      wdat = 16'($urandom);
      wdat[4:0] = 5'(ph_w[p]);
      set_reg(CFG_GLYPH_WIDTH, wdat);
      wdat = 16'($urandom);
      wdat[5:0] = 6'(ph_h[p]);
      set_reg(CFG_GLYPH_HEIGHT, wdat);
      settings_run++;
      h = glyph_h();

      // glyph rows for space, the next code, the top of the printable range and two more
      glyph_set[0] = 32;
      glyph_set[1] = 33;
      glyph_set[2] = 126;
      glyph_set[3] = $urandom_range(34, 125);
      glyph_set[4] = $urandom_range(34, 125);
      for (k = 0; k < 5; k++) begin
        for (r = 0; r < h; r++) begin
          it.op   = OP_LOAD;
          it.sx   = 8'($urandom);
          it.sy   = 8'($urandom);
          it.code = 8'($urandom);
          it.addr = 12'(((glyph_set[k] - 32) * h + r) % GLYPH_WORDS);
          it.word = 16'($urandom);
          drive_item(it, CHK_MODEL);
        end
      end

      // codes whose rows are all loaded for this height
      ready_codes.delete();
      for (c = 32; c <= 126; c++) begin
        ok = 1'b1;
        for (r = 0; r < h; r++)
          if (!font_written[((c - 32) * h + r) % GLYPH_WORDS]) ok = 1'b0;
        if (ok) ready_codes.push_back(c);
      end

      n = 0;
      while (n < RAND_PER_PHASE) begin
        it.sx   = 8'($urandom);
        it.sy   = 8'($urandom);
        it.code = 8'($urandom);
        it.addr = 12'($urandom);
        it.word = 16'($urandom);
        sel = $urandom_range(0, 99);
        // mostly well-formed strings: begin, puts, ticks to drain each glyph
        if (drawing) begin
          if (sel < 86)      it.op = OP_TICK;
          else if (sel < 91) it.op = OP_PUT;
          else if (sel < 96) it.op = OP_LOAD;
          else               it.op = OP_BEGIN;
        end else if (halted) begin
          if (sel < 55)      it.op = OP_BEGIN;
          else if (sel < 75) it.op = OP_PUT;
          else if (sel < 85) it.op = OP_TICK;
          else               it.op = OP_LOAD;
        end else begin
          if (sel < 60)      it.op = OP_PUT;
          else if (sel < 75) it.op = OP_BEGIN;
          else if (sel < 85) it.op = OP_TICK;
          else               it.op = OP_LOAD;
          // a code that would be drawn must have its rows loaded
          if (it.op == OP_PUT) begin
            if ($urandom_range(0, 99) < 85)
              it.code = 8'(ready_codes[$urandom_range(0, ready_codes.size() - 1)]);
            else if ($urandom_range(0, 1) == 0)
              it.code = 8'($urandom_range(0, 31));
            else
              it.code = 8'($urandom_range(127, 255));
          end
        end
        if (it.op == OP_BEGIN) begin
          sel = $urandom_range(0, 99);
          if (sel < 40)      it.sx = 8'($urandom_range(SCREEN_WIDTH - 20, SCREEN_WIDTH - 1));
          else if (sel < 80) it.sx = 8'($urandom_range(0, SCREEN_WIDTH - 1));
          if ($urandom_range(0, 99) < 80) it.sy = 8'($urandom_range(0, SCREEN_HEIGHT - 1));
        end
        // idle ticks are ignored by the block and do not count
        if (it.op != OP_TICK || drawing) n++;
        drive_item(it, CHK_MODEL);
        // now and then hold off until the output side has caught up
        if ($urandom_range(0, 299) == 0) settle();
      end

      // finish the glyph in flight before the next register change
      while (drawing) begin
        it.op = OP_TICK;
        drive_item(it, CHK_MODEL);
      end
    end

    settle();
    calm = 1'b0;

    $display("ran %0d input beats and %0d output beats over %0d glyph settings",
             beats_in, beats_out, settings_run + 1);
    $display("%0d characters drawn, %0d dropped, %0d mismatches",
             glyphs_drawn, chars_dropped, errors);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
src/gtr_pkg.sv
src/gtr_front.sv
src/gtr_back.sv
src/glyph_text_renderer_top.sv
bench/tb.sv
